/* hdl/ssd_pkg.sv */
// Shared constants for the segment-to-segment distance pipeline.
package ssd_pkg;

	// Fraction bits of the segment parameters t1 and t2 (unsigned Q1.16)
	localparam int T_FRAC = 16;

endpackage

/* hdl/segment_segment_distance.sv */
// Top level: closest approach between two 3D segments, fully pipelined.
//
// Input stream (s_axis_*): one transaction carries both segments, twelve
// signed coordinates of COORD_BITS each. Output stream (m_axis_*): one
// transaction per input, carrying the gap length and the midpoint of the
// closest points; tuser flags a zero denominator (parallel or degenerate),
// in which case the gap is all ones and the midpoint is zero.
// Throughput: one transaction per clock while the receiver takes every result.
// Most of the depth lies in the one-bit-per-stage divider for t1/t2 and
// the one-bit-per-stage square root for the gap.
// The whole pipeline advances together: when the output holds a result that
// the receiver does not take, every stage holds and s_axis_tready drops, so
// nothing is lost or repeated. The last rank is the output register, so a
// new input is still taken in any cycle the receiver takes the current one.
// Reset clears the valid bits only; input can be taken as soon as reset is released.
module segment_segment_distance #(
	parameter int COORD_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// first_start_x/y/z, first_end_x/y/z, second_start_x/y/z, second_end_x/y/z
	input  logic [((12*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// gap_length, mid_x, mid_y, mid_z
	output logic [((4*COORD_BITS+7)/8)*8-1:0]     m_axis_tdata,
	// parallel_flag
	output logic                                  m_axis_tuser
);

	localparam int CB    = COORD_BITS;
	localparam int TF    = ssd_pkg::T_FRAC;
	localparam int DW    = CB + 1;
	localparam int PW    = 2 * DW;
	localparam int DOTW  = PW + 2;
	localparam int NW    = 2 * DOTW + 1;
	localparam int TW    = TF + 1;
	localparam int TPW   = DW + TW + 1;
	localparam int DPW   = DW + TF + 4;
	localparam int SW    = 2 * DPW + 2;
	localparam int OUT_W = ((4 * CB + 7) / 8) * 8;
	localparam int LAT   = TF + 13 + CB;
	localparam int DLYA  = TF + 7;
	localparam int MW    = 3 * CB + 1;
	localparam logic signed [DPW-1:0] MID_HI = {{(DPW-CB+1){1'b0}}, {(CB-1){1'b1}}};
	localparam logic signed [DPW-1:0] MID_LO = {{(DPW-CB+1){1'b1}}, {(CB-1){1'b0}}};

	logic                  en;
	logic [LAT-1:0]        vld_q;
	logic signed [CB-1:0]  crd [12];

	logic signed [DW-1:0]  l1_s1 [3], l2_s1 [3], w_s1 [3], ps_s1 [3];
	logic signed [PW-1:0]  ap_s2 [3], bp_s2 [3], cp_s2 [3], dp_s2 [3], ep_s2 [3];
	logic signed [DOTW-1:0] a_s3, b_s3, c_s3, d_s3, e_s3;
	logic signed [2*DOTW-1:0] ac, bsq, be, cd, ae, bd;
	logic signed [NW-1:0]  den_s6, n1_s6, n2_s6;
	logic                  flag_d;
	logic [TW-1:0]         t1, t2;
	logic [12*DW-1:0]      da_in, da_out;
	logic signed [DW-1:0]  l1d [3], l2d [3], wd [3], psd [3];

	logic signed [TPW-1:0] pr1_s7 [3], pr2_s7 [3];
	logic signed [DW-1:0]  w_s7 [3], ps_s7 [3];
	logic                  flag_s7;

	logic signed [DPW-1:0] dp_c [3], m_c [3], msh_c [3];
	logic signed [CB-1:0]  mid_c [3];
	logic signed [DPW-1:0] dp_s8 [3];
	logic [MW-1:0]         mid_s8;

	logic signed [2*DPW-1:0] sq [3];
	logic [MW-1:0]         mid_d;
	logic [SW-1:0]         s_c;
	logic [2*CB-1:0]       v_s9;
	logic [MW-1:0]         mid_s9;
	logic [MW-1:0]         mid_o;
	logic [CB-1:0]         gap;

	// Global advance: the output rank is empty or being taken
	assign en            = !vld_q[LAT-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[LAT-1];

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
		end
	end

	// Unpack coordinates
	always_comb begin
		for (int k = 0; k < 12; k++) begin
			crd[k] = $signed(s_axis_tdata[k*CB +: CB]);
		end
	end

	// Stage 1: direction vectors, offset and coordinate sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				l1_s1[k] <= DW'(crd[3+k]) - DW'(crd[k]);
				l2_s1[k] <= DW'(crd[9+k]) - DW'(crd[6+k]);
				w_s1[k]  <= DW'(crd[k]) - DW'(crd[6+k]);
				ps_s1[k] <= DW'(crd[k]) + DW'(crd[6+k]);
			end
		end
	end

	// Stage 2: element products of the dot products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				ap_s2[k] <= l1_s1[k] * l1_s1[k];
				bp_s2[k] <= l1_s1[k] * l2_s1[k];
				cp_s2[k] <= l2_s1[k] * l2_s1[k];
				dp_s2[k] <= l1_s1[k] * w_s1[k];
				ep_s2[k] <= l2_s1[k] * w_s1[k];
			end
		end
	end

	// Stage 3: dot products a..e
	always_ff @(posedge clk) begin
		if (en) begin
			a_s3 <= DOTW'(ap_s2[0]) + DOTW'(ap_s2[1]) + DOTW'(ap_s2[2]);
			b_s3 <= DOTW'(bp_s2[0]) + DOTW'(bp_s2[1]) + DOTW'(bp_s2[2]);
			c_s3 <= DOTW'(cp_s2[0]) + DOTW'(cp_s2[1]) + DOTW'(cp_s2[2]);
			d_s3 <= DOTW'(dp_s2[0]) + DOTW'(dp_s2[1]) + DOTW'(dp_s2[2]);
			e_s3 <= DOTW'(ep_s2[0]) + DOTW'(ep_s2[1]) + DOTW'(ep_s2[2]);
		end
	end

	// Stages 4-5: wide products
	ssd_mul #(.W(DOTW)) u_mul_ac (.clk(clk), .en(en), .a(a_s3), .b(c_s3), .p(ac));
	ssd_mul #(.W(DOTW)) u_mul_bb (.clk(clk), .en(en), .a(b_s3), .b(b_s3), .p(bsq));
	ssd_mul #(.W(DOTW)) u_mul_be (.clk(clk), .en(en), .a(b_s3), .b(e_s3), .p(be));
	ssd_mul #(.W(DOTW)) u_mul_cd (.clk(clk), .en(en), .a(c_s3), .b(d_s3), .p(cd));
	ssd_mul #(.W(DOTW)) u_mul_ae (.clk(clk), .en(en), .a(a_s3), .b(e_s3), .p(ae));
	ssd_mul #(.W(DOTW)) u_mul_bd (.clk(clk), .en(en), .a(b_s3), .b(d_s3), .p(bd));

	// Stage 6: denominator and numerators
	always_ff @(posedge clk) begin
		if (en) begin
			den_s6 <= NW'(ac) - NW'(bsq);
			n1_s6  <= NW'(be) - NW'(cd);
			n2_s6  <= NW'(ae) - NW'(bd);
		end
	end

	// Parallel detection, carried alongside the dividers
	ssd_delay #(.W(1), .N(TF + 2)) u_dly_flag (
		.clk(clk), .en(en), .din(den_s6 == '0), .dout(flag_d)
	);

	ssd_div #(.NW(NW), .QB(TF)) u_div_t1 (
		.clk(clk), .en(en), .num(n1_s6), .den(den_s6), .t(t1)
	);
	ssd_div #(.NW(NW), .QB(TF)) u_div_t2 (
		.clk(clk), .en(en), .num(n2_s6), .den(den_s6), .t(t2)
	);

	// Geometry carried past the dot products and dividers
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			da_in[k*DW +: DW]     = l1_s1[k];
			da_in[(3+k)*DW +: DW] = l2_s1[k];
			da_in[(6+k)*DW +: DW] = w_s1[k];
			da_in[(9+k)*DW +: DW] = ps_s1[k];
			l1d[k] = $signed(da_out[k*DW +: DW]);
			l2d[k] = $signed(da_out[(3+k)*DW +: DW]);
			wd[k]  = $signed(da_out[(6+k)*DW +: DW]);
			psd[k] = $signed(da_out[(9+k)*DW +: DW]);
		end
	end

	ssd_delay #(.W(12 * DW), .N(DLYA)) u_dly_geo (
		.clk(clk), .en(en), .din(da_in), .dout(da_out)
	);

	// Stage 7: scale directions by the parameters
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				pr1_s7[k] <= l1d[k] * $signed({1'b0, t1});
				pr2_s7[k] <= l2d[k] * $signed({1'b0, t2});
				w_s7[k]   <= wd[k];
				ps_s7[k]  <= psd[k];
			end
			flag_s7 <= flag_d;
		end
	end

	// Point difference and midpoint, midpoint floored and saturated
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dp_c[k]  = (DPW'(w_s7[k]) <<< TF) + DPW'(pr1_s7[k]) - DPW'(pr2_s7[k]);
			m_c[k]   = (DPW'(ps_s7[k]) <<< TF) + DPW'(pr1_s7[k]) + DPW'(pr2_s7[k]);
			msh_c[k] = m_c[k] >>> (TF + 1);
			if (msh_c[k] > MID_HI) begin
				mid_c[k] = CB'(MID_HI);
			end else if (msh_c[k] < MID_LO) begin
				mid_c[k] = CB'(MID_LO);
			end else begin
				mid_c[k] = CB'(msh_c[k]);
			end
		end
	end

	// Stage 8
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				dp_s8[k] <= dp_c[k];
			end
			mid_s8 <= {flag_s7, mid_c[2], mid_c[1], mid_c[0]};
		end
	end

	// Squares of the difference components
	for (genvar k = 0; k < 3; k++) begin : g_sq
		ssd_mul #(.W(DPW)) u_mul_sq (
			.clk(clk), .en(en), .a(dp_s8[k]), .b(dp_s8[k]), .p(sq[k])
		);
	end

	ssd_delay #(.W(MW), .N(2)) u_dly_mid_a (
		.clk(clk), .en(en), .din(mid_s8), .dout(mid_d)
	);

	// Stage 9: squared distance, saturated into the root's range
	assign s_c = SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			if (mid_d[MW-1] || (s_c[SW-1:2*TF+2*CB] != '0)) begin
				v_s9 <= '1;
			end else begin
				v_s9 <= s_c[2*TF+2*CB-1:2*TF];
			end
			mid_s9 <= mid_d[MW-1] ? {1'b1, {(MW-1){1'b0}}} : mid_d;
		end
	end

	ssd_sqrt #(.W(CB)) u_sqrt (.clk(clk), .en(en), .v(v_s9), .root(gap));

	ssd_delay #(.W(MW), .N(CB)) u_dly_mid_b (
		.clk(clk), .en(en), .din(mid_s9), .dout(mid_o)
	);

	// Output packing
	assign m_axis_tdata = OUT_W'({mid_o[MW-2:0], gap});
	assign m_axis_tuser = mid_o[MW-1];

	// Parallel result carries the fixed gap and a zero midpoint
	a_par_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			(m_axis_tdata[CB-1:0] == '1) && (m_axis_tdata[4*CB-1:CB] == '0))
		else $error("parallel result not forced");

	// A held pipeline keeps every valid bit
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid bits moved during stall");

	// An accepted transaction enters the first rank
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> vld_q[0])
		else $error("accepted transaction lost");

endmodule

/* hdl/ssd_delay.sv */
// Delay line of N register ranks with a common clock enable.
module ssd_delay #(
	parameter int W = 8,
	parameter int N = 2
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] tap_q [N];

	// Shift one rank per enabled cycle
	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= din;
			for (int i = 1; i < N; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign dout = tap_q[N-1];

endmodule

/* hdl/ssd_mul.sv */
// Two-stage signed multiplier built from four half-width partial products.
module ssd_mul #(
	parameter int W = 52
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p
);

	localparam int LO = W / 2;
	localparam int HI = W - LO;
	localparam int PW = 2 * W;

	logic signed [LO:0]       al, bl;
	logic signed [HI-1:0]     ah, bh;
	logic signed [2*LO+1:0]   ll_s1;
	logic signed [LO+HI:0]    lh_s1, hl_s1;
	logic signed [2*HI-1:0]   hh_s1;

	// Split: low half unsigned, high half carries the sign
	assign al = $signed({1'b0, a[LO-1:0]});
	assign bl = $signed({1'b0, b[LO-1:0]});
	assign ah = $signed(a[W-1:LO]);
	assign bh = $signed(b[W-1:LO]);

	// Stage 1: partial products
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= al * bl;
			lh_s1 <= al * bh;
			hl_s1 <= ah * bl;
			hh_s1 <= ah * bh;
		end
	end

	// Stage 2: weighted sum
	always_ff @(posedge clk) begin
		if (en) begin
			p <= (PW'(hh_s1) <<< (2 * LO)) + ((PW'(lh_s1) + PW'(hl_s1)) <<< LO)
				+ PW'(ll_s1);
		end
	end

endmodule

/* hdl/ssd_div.sv */
// Pipelined clamped ratio num/den in Q1.QB, one quotient bit per stage.
module ssd_div #(
	parameter int NW = 105,
	parameter int QB = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [NW-1:0] num,
	input  logic signed [NW-1:0] den,
	output logic [QB:0]          t
);

	logic [NW-1:0]        dmag_s1;
	logic signed [NW:0]   nn_s1;
	logic [NW-1:0]        rem_s2, den_s2;
	logic                 zero_s2, one_s2;

	logic [NW-1:0]        rem_s [QB];
	logic [QB-1:0]        q_s [QB];
	logic [NW-1:0]        den_s [QB];
	logic                 zero_s [QB];
	logic                 one_s [QB];

	logic [NW-1:0]        rem_i [QB];
	logic [QB-1:0]        q_i [QB];
	logic [NW-1:0]        den_i [QB];
	logic                 zero_i [QB];
	logic                 one_i [QB];

	// Normalise so that the denominator is positive
	always_ff @(posedge clk) begin
		if (en) begin
			if (den[NW-1]) begin
				dmag_s1 <= NW'(-(NW+1)'(den));
				nn_s1   <= -(NW+1)'(num);
			end else begin
				dmag_s1 <= NW'(den);
				nn_s1   <= (NW+1)'(num);
			end
		end
	end

	// Clamp decisions
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s2  <= nn_s1[NW-1:0];
			den_s2  <= dmag_s1;
			zero_s2 <= nn_s1[NW] || (nn_s1 == '0);
			one_s2  <= !nn_s1[NW] && (nn_s1[NW-1:0] >= dmag_s1);
		end
	end

	// Restoring division stages
	for (genvar i = 0; i < QB; i++) begin : g_stage
		logic [NW:0]   r2;
		logic [NW+1:0] diff;

		if (i == 0) begin : g_first
			assign rem_i[i]  = rem_s2;
			assign q_i[i]    = '0;
			assign den_i[i]  = den_s2;
			assign zero_i[i] = zero_s2;
			assign one_i[i]  = one_s2;
		end else begin : g_next
			assign rem_i[i]  = rem_s[i-1];
			assign q_i[i]    = q_s[i-1];
			assign den_i[i]  = den_s[i-1];
			assign zero_i[i] = zero_s[i-1];
			assign one_i[i]  = one_s[i-1];
		end

		assign r2   = {rem_i[i], 1'b0};
		assign diff = {1'b0, r2} - {2'b00, den_i[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= diff[NW+1] ? r2[NW-1:0] : diff[NW-1:0];
				q_s[i]    <= {q_i[i][QB-2:0], !diff[NW+1]};
				den_s[i]  <= den_i[i];
				zero_s[i] <= zero_i[i];
				one_s[i]  <= one_i[i];
			end
		end
	end

	// Result with clamping to zero or one
	always_comb begin
		if (zero_s[QB-1]) begin
			t = '0;
		end else if (one_s[QB-1]) begin
			t = {1'b1, {QB{1'b0}}};
		end else begin
			t = {1'b0, q_s[QB-1]};
		end
	end

endmodule

/* hdl/ssd_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
module ssd_sqrt #(
	parameter int W = 24
) (
	input  logic           clk,
	input  logic           en,
	input  logic [2*W-1:0] v,
	output logic [W-1:0]   root
);

	localparam int RW = W + 3;

	logic [RW-1:0]  rem_s [W];
	logic [W-1:0]   root_s [W];
	logic [2*W-1:0] vr_s [W];

	logic [RW-1:0]  rem_i [W];
	logic [W-1:0]   root_i [W];
	logic [2*W-1:0] vr_i [W];

	for (genvar i = 0; i < W; i++) begin : g_stage
		logic [RW-1:0] cur, trial;
		logic          ge;

		if (i == 0) begin : g_first
			assign rem_i[i]  = '0;
			assign root_i[i] = '0;
			assign vr_i[i]   = v;
		end else begin : g_next
			assign rem_i[i]  = rem_s[i-1];
			assign root_i[i] = root_s[i-1];
			assign vr_i[i]   = vr_s[i-1];
		end

		// Bring down the next two bits and try the new root bit
		assign cur   = {rem_i[i][RW-3:0], vr_i[i][2*W-1:2*W-2]};
		assign trial = RW'({root_i[i], 2'b01});
		assign ge    = (cur >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? (cur - trial) : cur;
				root_s[i] <= {root_i[i][W-2:0], ge};
				vr_s[i]   <= {vr_i[i][2*W-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[W-1];

endmodule

/* tb/sv/segment_segment_distance_tb.sv */
// Self-checking testbench for the segment-to-segment closest approach pipeline.
module segment_segment_distance_tb;

	localparam int  CB         = 24;
	localparam int  LATENCY    = ssd_pkg::T_FRAC + CB + 13;
	localparam int  CYCLE_MAX  = 600000;
	localparam int  GAP_FULL   = 24'hFFFFFF;
	localparam longint MID_HI  = 8388607;
	localparam longint MID_LO  = -8388608;

	typedef logic [11:0][CB-1:0] seg_pair_t;
	typedef logic signed [255:0] wide_t;

	typedef struct packed {
		logic [CB-1:0] gap;
		logic [CB-1:0] mx;
		logic [CB-1:0] my;
		logic [CB-1:0] mz;
		logic          par;
	} approach_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [12*CB-1:0]  s_axis_tdata;  // first_start_x/y/z, first_end_x/y/z, second_start/end x/y/z
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [4*CB-1:0]   m_axis_tdata;  // gap_length, mid_x, mid_y, mid_z
	logic              m_axis_tuser;  // parallel_flag

	approach_t pending_approach[$];
	int        errors;
	int        cycles;
	bit        tx_gaps_on;
	bit        rx_stalls_on;
	int        rx_stall_left;

	segment_segment_distance #(.COORD_BITS(CB)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	// Clock, period 4
	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	// Wide dot product of two difference vectors
	function automatic wide_t dot3(longint x0, longint x1, longint x2,
			longint y0, longint y1, longint y2);
		wide_t r;
		r = wide_t'(x0) * wide_t'(y0) + wide_t'(x1) * wide_t'(y1) + wide_t'(x2) * wide_t'(y2);
		return r;
	endfunction

	// Clamped Q1.16 segment parameter num/den, den nonzero
	function automatic longint seg_param(wide_t num, wide_t den);
		wide_t q;
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		if (num <= 0) return 0;
		if (num >= den) return longint'(1) << ssd_pkg::T_FRAC;
		q = (num <<< ssd_pkg::T_FRAC) / den;
		return longint'(q);
	endfunction

	// Expected gap and midpoint for one segment pair
	function automatic approach_t closest_approach(seg_pair_t sp);
		longint    p[12];
		longint    l1[3], l2[3], w[3];
		longint    t1, t2, dp, m, mv, g, cand;
		wide_t     a, b, c, d, e, den, s;
		logic [63:0] v;
		approach_t r;
		for (int k = 0; k < 12; k++) p[k] = longint'($signed(sp[k]));
		for (int k = 0; k < 3; k++) begin
			l1[k] = p[3+k] - p[k];
			l2[k] = p[9+k] - p[6+k];
			w[k]  = p[k] - p[6+k];
		end
		a = dot3(l1[0], l1[1], l1[2], l1[0], l1[1], l1[2]);
		b = dot3(l1[0], l1[1], l1[2], l2[0], l2[1], l2[2]);
		c = dot3(l2[0], l2[1], l2[2], l2[0], l2[1], l2[2]);
		d = dot3(l1[0], l1[1], l1[2], w[0], w[1], w[2]);
		e = dot3(l2[0], l2[1], l2[2], w[0], w[1], w[2]);
		den = a * c - b * b;
		r = '0;
		if (den == 0) begin
			r.gap = GAP_FULL;
			r.par = 1'b1;
			return r;
		end
		t1 = seg_param(b * e - c * d, den);
		t2 = seg_param(a * e - b * d, den);
		s = 0;
		for (int k = 0; k < 3; k++) begin
			dp = w[k] * (longint'(1) << ssd_pkg::T_FRAC) + l1[k] * t1 - l2[k] * t2;
			m  = (p[k] + p[6+k]) * (longint'(1) << ssd_pkg::T_FRAC) + l1[k] * t1
				+ l2[k] * t2;
			s  = s + wide_t'(dp) * wide_t'(dp);
			mv = m >>> (ssd_pkg::T_FRAC + 1);
			if (mv > MID_HI) mv = MID_HI;
			if (mv < MID_LO) mv = MID_LO;
			case (k)
				0: r.mx = mv[CB-1:0];
				1: r.my = mv[CB-1:0];
				default: r.mz = mv[CB-1:0];
			endcase
		end
		// floor of the root, taken on the sum scaled back to input units
		if (s < (wide_t'(1) <<< 80)) begin
			v = 64'(s >>> 32);
			g = 0;
			for (int i = 23; i >= 0; i--) begin
				cand = g | (longint'(1) << i);
				if (cand * cand <= longint'(v)) g = cand;
			end
			r.gap = g[CB-1:0];
		end else begin
			r.gap = GAP_FULL;
		end
		return r;
	endfunction

	// Cycle count and run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_MAX) begin
			$display("[segment_segment_distance] ERROR");
			$finish;
		end
	end

	// Receiver back-pressure
	always @(negedge clk) begin
		if (!arst_n || !rx_stalls_on) begin
			m_axis_tready <= 1'b1;
			rx_stall_left <= 0;
		end else if (rx_stall_left > 0) begin
			m_axis_tready <= 1'b0;
			rx_stall_left <= rx_stall_left - 1;
		end else if ($urandom_range(0, 99) < 70) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= 1'b0;
			rx_stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
				: $urandom_range(0, 2);
		end
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin
		approach_t exp_r, got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[CB-1:0], m_axis_tdata[2*CB-1:CB],
				m_axis_tdata[3*CB-1:2*CB], m_axis_tdata[4*CB-1:3*CB], m_axis_tuser};
			if (pending_approach.size() == 0) begin
				$display("%0t unexpected result: expected none actual %h", $realtime, got);
				errors++;
			end else begin
				exp_r = pending_approach.pop_front();
				if (got.gap !== exp_r.gap)
					$display("%0t gap_length: expected %h actual %h", $realtime, exp_r.gap, got.gap);
				if (got.mx !== exp_r.mx)
					$display("%0t mid_x: expected %h actual %h", $realtime, exp_r.mx, got.mx);
				if (got.my !== exp_r.my)
					$display("%0t mid_y: expected %h actual %h", $realtime, exp_r.my, got.my);
				if (got.mz !== exp_r.mz)
					$display("%0t mid_z: expected %h actual %h", $realtime, exp_r.mz, got.mz);
				if (got.par !== exp_r.par)
					$display("%0t parallel_flag: expected %b actual %b", $realtime, exp_r.par, got.par);
				if (got !== exp_r) errors++;
			end
		end
	end

	// Send one segment pair, with a random lead-in gap when tx_gaps_on is set
	task automatic send_pair(seg_pair_t sp);
		int gap;
		gap = 0;
		if (tx_gaps_on) begin
			case ($urandom_range(0, 19)) inside
				[0:11]: gap = 0;
				19: gap = $urandom_range(10, 40);
				default: gap = $urandom_range(1, 3);
			endcase
		end
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  = sp;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		pending_approach.push_back(closest_approach(sp));
		@(negedge clk);
	endtask

	task automatic stop_sending();
		s_axis_tvalid = 1'b0;
	endtask

	task automatic wait_drained();
		stop_sending();
		while (pending_approach.size() != 0) @(negedge clk);
	endtask

	function automatic logic [CB-1:0] small_coord(int span);
		return CB'($urandom_range(0, 2*span) - span);
	endfunction

	// Build one pair from a chosen category
	function automatic seg_pair_t make_pair(int kind);
		seg_pair_t sp;
		int k;
		case (kind)
			0: for (int i = 0; i < 12; i++) sp[i] = CB'($urandom());
			1: for (int i = 0; i < 12; i++) sp[i] = small_coord(3000);
			2: begin
				// second segment a scaled copy of the first: zero denominator
				for (int i = 0; i < 9; i++) sp[i] = small_coord(20000);
				k = $urandom_range(0, 6) - 3;
				for (int i = 0; i < 3; i++)
					sp[9+i] = sp[6+i] + CB'(k * ($signed(sp[3+i]) - $signed(sp[i])));
			end
			3: begin
				// one segment collapsed to a point
				for (int i = 0; i < 12; i++) sp[i] = small_coord(100000);
				for (int i = 0; i < 3; i++) sp[9+i] = sp[6+i];
			end
			default: for (int i = 0; i < 12; i++) sp[i] = small_coord(60);
		endcase
		return sp;
	endfunction

	// Corners of the coordinate range and textbook layouts
	task automatic test_corner_cases();
		seg_pair_t sp;
		sp = '0; send_pair(sp);
		sp = '1; send_pair(sp);
		for (int i = 0; i < 12; i++) sp[i] = (i % 2) ? 24'h800000 : 24'h7FFFFF;
		send_pair(sp);
		for (int i = 0; i < 12; i++) sp[i] = (i < 6) ? 24'h7FFFFF : 24'h800000;
		send_pair(sp);
		for (int i = 0; i < 12; i++) sp[i] = (i % 3 == 0) ? 24'h800000 : 24'h7FFFFF;
		send_pair(sp);
		// crossing segments along x and y, one above the other
		sp = '0;
		sp[0] = -CB'(512); sp[3] = 24'd512;
		sp[7] = -CB'(512); sp[10] = 24'd512; sp[8] = 24'd256; sp[11] = 24'd256;
		send_pair(sp);
		// skew lines whose closest points lie beyond both ends
		sp = '0;
		sp[3] = 24'd256;
		sp[6] = 24'd2560; sp[7] = 24'd256; sp[9] = 24'd2560; sp[10] = 24'd1024;
		sp[11] = 24'd512;
		send_pair(sp);
		// extreme skew lines: gaps up to the top of the gap's range
		sp = '0;
		sp[0] = 24'h800000; sp[3] = 24'h7FFFFF;
		sp[7] = 24'h800000; sp[10] = 24'h7FFFFF;
		sp[8] = 24'h800000; sp[11] = 24'h800000;
		send_pair(sp);
		sp[8] = 24'h7FFFFF; sp[11] = 24'h7FFFFF; sp[2] = 24'h800000; sp[5] = 24'h800000;
		send_pair(sp);
		for (int i = 0; i < 6; i++) send_pair(make_pair(1));
	endtask

	// Zero denominator: parallel and degenerate segments
	task automatic test_parallel_cases();
		for (int i = 0; i < 4; i++) send_pair(make_pair(2));
		for (int i = 0; i < 3; i++) send_pair(make_pair(3));
	endtask

	// Sender holds off until the pipeline has emptied, then resumes
	task automatic test_drain_pause();
		for (int i = 0; i < 20; i++) send_pair(make_pair($urandom_range(0, 4)));
		wait_drained();
		repeat (LATENCY) @(negedge clk);
		for (int i = 0; i < 20; i++) send_pair(make_pair($urandom_range(0, 4)));
	endtask

	// Full rate on both sides
	task automatic test_back_to_back();
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		for (int i = 0; i < 120; i++) send_pair(make_pair($urandom_range(0, 4)));
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
	endtask

	// Mixed random stream with gaps and back-pressure
	task automatic test_random_stream(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 30) send_pair(make_pair(0));
			else if (r < 70) send_pair(make_pair(1));
			else if (r < 80) send_pair(make_pair(2));
			else if (r < 88) send_pair(make_pair(3));
			else send_pair(make_pair(4));
		end
	endtask

	initial begin
		errors        = 0;
		cycles        = 0;
		tx_gaps_on    = 1'b1;
		rx_stalls_on  = 1'b1;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b1;
		arst_n        = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_corner_cases();
		test_parallel_cases();
		test_drain_pause();
		test_back_to_back();
		test_random_stream(720);
		wait_drained();
		repeat (LATENCY + 10) @(negedge clk);
		if (errors == 0) begin
			$display("[segment_segment_distance] OK");
		end else begin
			$display("[segment_segment_distance] ERROR");
		end
		$finish;
	end

endmodule

/* filelist.f */
hdl/ssd_pkg.sv
hdl/ssd_delay.sv
hdl/ssd_mul.sv
hdl/ssd_div.sv
hdl/ssd_sqrt.sv
hdl/segment_segment_distance.sv
tb/sv/segment_segment_distance_tb.sv
